[rtl/gps_pkg.sv]
`timescale 1ns / 1ps

package gps_pkg;

    localparam logic [1:0] FUNC_GRID_WRITE    = 2'd0;
    localparam logic [1:0] FUNC_PATTERN_WRITE = 2'd1;
    localparam logic [1:0] FUNC_SEARCH        = 2'd2;

    localparam logic [1:0] REG_GRID_ROWS    = 2'd0;
    localparam logic [1:0] REG_GRID_COLS    = 2'd1;
    localparam logic [1:0] REG_PATTERN_ROWS = 2'd2;
    localparam logic [1:0] REG_PATTERN_COLS = 2'd3;

    localparam logic [6:0] GRID_ROWS_RESET    = 7'd64;
    localparam logic [6:0] GRID_COLS_RESET    = 7'd64;
    localparam logic [4:0] PATTERN_ROWS_RESET = 5'd16;
    localparam logic [4:0] PATTERN_COLS_RESET = 5'd16;

    typedef struct packed {
        logic [6:0] grid_rows;
        logic [6:0] grid_cols;
        logic [4:0] pattern_rows;
        logic [4:0] pattern_cols;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic found;
    } srch_stat_t;

endpackage

[rtl/gps_cmd_if.sv]
`timescale 1ns / 1ps

interface gps_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] cell_value;

    modport source (output valid, output func, output row, output col,
                    output cell_value, input ready);
    modport sink (input valid, input func, input row, input col,
                  input cell_value, output ready);
endinterface

[rtl/gps_rsp_if.sv]
`timescale 1ns / 1ps

interface gps_rsp_if;
    logic valid;
    logic ready;
    logic found;

    modport source (output valid, output found, input ready);
    modport sink (input valid, input found, output ready);
endinterface

[rtl/gps_ram.sv]
`timescale 1ns / 1ps

module gps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/gps_cfg.sv]
`timescale 1ns / 1ps

module gps_cfg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output gps_pkg::cfg_t    cfg
);

    gps_pkg::cfg_t cfg_reg;
    gps_pkg::cfg_t cfg_next;
    logic          wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                gps_pkg::REG_GRID_ROWS:    cfg_next.grid_rows    = pwdata[6:0];
                gps_pkg::REG_GRID_COLS:    cfg_next.grid_cols    = pwdata[6:0];
                gps_pkg::REG_PATTERN_ROWS: cfg_next.pattern_rows = pwdata[4:0];
                gps_pkg::REG_PATTERN_COLS: cfg_next.pattern_cols = pwdata[4:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_rows    <= gps_pkg::GRID_ROWS_RESET;
            cfg_reg.grid_cols    <= gps_pkg::GRID_COLS_RESET;
            cfg_reg.pattern_rows <= gps_pkg::PATTERN_ROWS_RESET;
            cfg_reg.pattern_cols <= gps_pkg::PATTERN_COLS_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            gps_pkg::REG_GRID_ROWS:    prdata = {25'd0, cfg_reg.grid_rows};
            gps_pkg::REG_GRID_COLS:    prdata = {25'd0, cfg_reg.grid_cols};
            gps_pkg::REG_PATTERN_ROWS: prdata = {27'd0, cfg_reg.pattern_rows};
            gps_pkg::REG_PATTERN_COLS: prdata = {27'd0, cfg_reg.pattern_cols};
            default:                   prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/gps_search.sv]
`timescale 1ns / 1ps

module gps_search #(
    parameter int MAX_GRID_ROWS = 64,
    parameter int MAX_GRID_COLS = 64,
    parameter int MAX_PAT_ROWS  = 16,
    parameter int MAX_PAT_COLS  = 16,
    localparam int GDEPTH = MAX_GRID_ROWS * MAX_GRID_COLS,
    localparam int PDEPTH = MAX_PAT_ROWS * MAX_PAT_COLS,
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1,
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  gps_pkg::cfg_t         cfg,
    input  logic                  out_free,
    input  logic [7:0]            g_rdata,
    input  logic [7:0]            p_rdata,
    output logic [GAW-1:0]        g_raddr,
    output logic [PAW-1:0]        p_raddr,
    output gps_pkg::srch_stat_t   stat
);

    localparam int GR_LIM = (MAX_GRID_ROWS < 127) ? MAX_GRID_ROWS : 127;
    localparam int GC_LIM = (MAX_GRID_COLS < 127) ? MAX_GRID_COLS : 127;
    localparam int PR_LIM = (MAX_PAT_ROWS < 31) ? MAX_PAT_ROWS : 31;
    localparam int PC_LIM = (MAX_PAT_COLS < 31) ? MAX_PAT_COLS : 31;
    localparam int GR_W   = (GR_LIM > 1) ? $clog2(GR_LIM + 1) : 1;
    localparam int GC_W   = (GC_LIM > 1) ? $clog2(GC_LIM + 1) : 1;
    localparam int PR_W   = (PR_LIM > 1) ? $clog2(PR_LIM + 1) : 1;
    localparam int PC_W   = (PC_LIM > 1) ? $clog2(PC_LIM + 1) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_CMP,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic            found_reg, found_next;
    logic [GR_W-1:0] r_reg, r_next;
    logic [GC_W-1:0] c_reg, c_next;
    logic [PR_W-1:0] i_reg, i_next;
    logic [PC_W-1:0] j_reg, j_next;
    logic [GAW-1:0]  rbase_reg, rbase_next;
    logic [GAW-1:0]  gbase_reg, gbase_next;
    logic [GAW-1:0]  gline_reg, gline_next;
    logic [GAW-1:0]  gaddr_reg, gaddr_next;
    logic [PAW-1:0]  pline_reg, pline_next;
    logic [PAW-1:0]  paddr_reg, paddr_next;

    logic [GR_W-1:0] gr;
    logic [GC_W-1:0] gc;
    logic [PR_W-1:0] pr;
    logic [PC_W-1:0] pc;
    logic [GR_W-1:0] rlim;
    logic [GC_W-1:0] clim;

    // Dimensions above the storage limits saturate to those limits.
    assign gr = (int'(cfg.grid_rows) > MAX_GRID_ROWS) ? GR_W'(MAX_GRID_ROWS)
                                                      : GR_W'(cfg.grid_rows);
    assign gc = (int'(cfg.grid_cols) > MAX_GRID_COLS) ? GC_W'(MAX_GRID_COLS)
                                                      : GC_W'(cfg.grid_cols);
    assign pr = (int'(cfg.pattern_rows) > MAX_PAT_ROWS) ? PR_W'(MAX_PAT_ROWS)
                                                        : PR_W'(cfg.pattern_rows);
    assign pc = (int'(cfg.pattern_cols) > MAX_PAT_COLS) ? PC_W'(MAX_PAT_COLS)
                                                        : PC_W'(cfg.pattern_cols);
    assign rlim = GR_W'(int'(gr) - int'(pr));
    assign clim = GC_W'(int'(gc) - int'(pc));

    always_comb
    begin
        state_next = state_reg;
        found_next = found_reg;
        r_next     = r_reg;
        c_next     = c_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        rbase_next = rbase_reg;
        gbase_next = gbase_reg;
        gline_next = gline_reg;
        gaddr_next = gaddr_reg;
        pline_next = pline_reg;
        paddr_next = paddr_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (gr == '0 || gc == '0 || pr == '0 || pc == '0 ||
                    int'(pr) > int'(gr) || int'(pc) > int'(gc))
                begin
                    found_next = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    r_next     = '0;
                    c_next     = '0;
                    i_next     = '0;
                    j_next     = '0;
                    rbase_next = '0;
                    gbase_next = '0;
                    gline_next = '0;
                    gaddr_next = '0;
                    pline_next = '0;
                    paddr_next = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CMP;
            end
            S_CMP:
            begin
                state_next = S_READ;
                if (g_rdata == p_rdata)
                begin
                    if (int'(j_reg) + 1 == int'(pc))
                    begin
                        if (int'(i_reg) + 1 == int'(pr))
                        begin
                            found_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            i_next     = i_reg + PR_W'(1);
                            j_next     = '0;
                            pline_next = pline_reg + PAW'(MAX_PAT_COLS);
                            paddr_next = pline_reg + PAW'(MAX_PAT_COLS);
                            gline_next = gline_reg + GAW'(MAX_GRID_COLS);
                            gaddr_next = gline_reg + GAW'(MAX_GRID_COLS);
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + PC_W'(1);
                        gaddr_next = gaddr_reg + GAW'(1);
                        paddr_next = paddr_reg + PAW'(1);
                    end
                end
                else
                begin
                    i_next     = '0;
                    j_next     = '0;
                    pline_next = '0;
                    paddr_next = '0;
                    if (c_reg == clim)
                    begin
                        if (r_reg == rlim)
                        begin
                            found_next = 1'b0;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            r_next     = r_reg + GR_W'(1);
                            c_next     = '0;
                            rbase_next = rbase_reg + GAW'(MAX_GRID_COLS);
                            gbase_next = rbase_reg + GAW'(MAX_GRID_COLS);
                            gline_next = rbase_reg + GAW'(MAX_GRID_COLS);
                            gaddr_next = rbase_reg + GAW'(MAX_GRID_COLS);
                        end
                    end
                    else
                    begin
                        c_next     = c_reg + GC_W'(1);
                        gbase_next = gbase_reg + GAW'(1);
                        gline_next = gbase_reg + GAW'(1);
                        gaddr_next = gbase_reg + GAW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            found_reg <= 1'b0;
            r_reg     <= '0;
            c_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            rbase_reg <= '0;
            gbase_reg <= '0;
            gline_reg <= '0;
            gaddr_reg <= '0;
            pline_reg <= '0;
            paddr_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            found_reg <= found_next;
            r_reg     <= r_next;
            c_reg     <= c_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            rbase_reg <= rbase_next;
            gbase_reg <= gbase_next;
            gline_reg <= gline_next;
            gaddr_reg <= gaddr_next;
            pline_reg <= pline_next;
            paddr_reg <= paddr_next;
        end
    end

    assign g_raddr    = gaddr_reg;
    assign p_raddr    = paddr_reg;
    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.done  = (state_reg == S_DONE) && out_free;
    assign stat.found = found_reg;

endmodule

[rtl/grid_pattern_search_top.sv]
`timescale 1ns / 1ps

// Channel  Modport  Moves
// cmd      sink     one command item: func, row, col, cell_value
// rsp      source   one result item per search: found
// apb      slave    four dimension registers at byte addresses 0, 4, 8 and 12
//
// A grid or pattern write item leaves cmd ready.
// A search goes through a setup state, then reads and compares cells through the
// shared compare unit and the registered store reads, and then hands
// over the result; cmd is not ready for that whole time.
// Reset clears the control state and the registers; the stores are not cleared.
// A result waits in the output register while rsp stalls, and write items are
// still taken; a later search holds its answer until that register is free.

module grid_pattern_search_top #(
    parameter int MAX_GRID_ROWS = 64,
    parameter int MAX_GRID_COLS = 64,
    parameter int MAX_PAT_ROWS  = 16,
    parameter int MAX_PAT_COLS  = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    gps_cmd_if.sink     cmd,
    gps_rsp_if.source   rsp
);

    localparam int GDEPTH = MAX_GRID_ROWS * MAX_GRID_COLS;
    localparam int PDEPTH = MAX_PAT_ROWS * MAX_PAT_COLS;
    localparam int GAW    = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int PAW    = (PDEPTH > 1) ? $clog2(PDEPTH) : 1;

    gps_pkg::cfg_t       cfg;
    gps_pkg::srch_stat_t stat;

    logic           accept;
    logic           g_we;
    logic           p_we;
    logic           start;
    logic [GAW-1:0] g_waddr;
    logic [PAW-1:0] p_waddr;
    logic [GAW-1:0] g_raddr;
    logic [PAW-1:0] p_raddr;
    logic [7:0]     g_rdata;
    logic [7:0]     p_rdata;
    logic           rsp_valid_reg, rsp_valid_next;
    logic           rsp_found_reg, rsp_found_next;

    assign cmd.ready = !stat.busy;
    assign accept    = cmd.valid && cmd.ready;

    assign g_we  = accept && (cmd.func == gps_pkg::FUNC_GRID_WRITE) &&
                   (int'(cmd.row) < MAX_GRID_ROWS) && (int'(cmd.col) < MAX_GRID_COLS);
    assign p_we  = accept && (cmd.func == gps_pkg::FUNC_PATTERN_WRITE) &&
                   (int'(cmd.row) < MAX_PAT_ROWS) && (int'(cmd.col) < MAX_PAT_COLS);
    assign start = accept && (cmd.func == gps_pkg::FUNC_SEARCH);

    assign g_waddr = GAW'(int'(cmd.row) * MAX_GRID_COLS + int'(cmd.col));
    assign p_waddr = PAW'(int'(cmd.row) * MAX_PAT_COLS + int'(cmd.col));

    gps_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gps_ram #(
        .WIDTH (8),
        .DEPTH (GDEPTH)
    ) u_grid_ram (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (cmd.cell_value),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    gps_ram #(
        .WIDTH (8),
        .DEPTH (PDEPTH)
    ) u_pattern_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (cmd.cell_value),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    gps_search #(
        .MAX_GRID_ROWS (MAX_GRID_ROWS),
        .MAX_GRID_COLS (MAX_GRID_COLS),
        .MAX_PAT_ROWS  (MAX_PAT_ROWS),
        .MAX_PAT_COLS  (MAX_PAT_COLS)
    ) u_search (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cfg      (cfg),
        .out_free (!rsp_valid_reg),
        .g_rdata  (g_rdata),
        .p_rdata  (p_rdata),
        .g_raddr  (g_raddr),
        .p_raddr  (p_raddr),
        .stat     (stat)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_found_next = rsp_found_reg;
        if (stat.done)
        begin
            rsp_valid_next = 1'b1;
            rsp_found_next = stat.found;
        end
        else if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_found_reg <= rsp_found_next;
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.found = rsp_found_reg;

endmodule
